>>> design/kalman_angle_bias_filter_macros.svh
// Assertion macros shared by the checker of the angle and bias filter.
// Needs only a clock and a reset named clk_i and rst_ni where it is used.
`ifndef KALMAN_ANGLE_BIAS_FILTER_MACROS_SVH
`define KALMAN_ANGLE_BIAS_FILTER_MACROS_SVH

// Property that must hold at every edge outside reset.
`define KAB_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("kab assertion failed");

// Implication checked in the next cycle.
`define KAB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kab assertion failed");

`endif

>>> design/kab_pkg.sv
// Package of the angle and bias filter: widths, codes, reset values, types and
// saturation helpers. Used by the filter, its multiplier and its divider.
package kab_pkg;

  localparam int unsigned NoiseW = 24;
  localparam int unsigned AngW   = 32;
  localparam int unsigned CovW   = 48;
  localparam int unsigned WideW  = 58;
  localparam int unsigned ProdW  = 57;
  localparam int unsigned DenW   = 48;
  localparam int unsigned QuotW  = 31;

  localparam logic [1:0] RegAngleNoise   = 2'd0;
  localparam logic [1:0] RegBiasNoise    = 2'd1;
  localparam logic [1:0] RegMeasureNoise = 2'd2;

  localparam logic [NoiseW-1:0] AngleNoiseRst   = 24'd167772;
  localparam logic [NoiseW-1:0] BiasNoiseRst    = 24'd50332;
  localparam logic [NoiseW-1:0] MeasureNoiseRst = 24'd167772;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_MUL_LO   = 7'b0000010,
    ST_MUL_HI   = 7'b0000100,
    ST_MUL_WB   = 7'b0001000,
    ST_DIV_GO   = 7'b0010000,
    ST_DIV_WAIT = 7'b0100000,
    ST_FINISH   = 7'b1000000
  } state_e;

  typedef enum logic [3:0] {
    OP_ANG_PRED, OP_BB_DT, OP_INNER_DT, OP_QB_DT, OP_Y_K0,
    OP_Y_K1, OP_BA, OP_BB, OP_AA, OP_AB
  } op_e;

  typedef struct packed {
    logic lo_en;
    logic hi_en;
  } mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [AngW-1:0] sat32(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = 58'sh7FFFFFFF;
    lo = -58'sh80000000;
    if (v > hi) return 32'sh7FFFFFFF;
    else if (v < lo) return -32'sh80000000;
    else return v[AngW-1:0];
  endfunction

  function automatic logic signed [CovW-1:0] sat48(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = 58'sh7FFFFFFFFFFF;
    lo = -58'sh800000000000;
    if (v > hi) return 48'sh7FFFFFFFFFFF;
    else if (v < lo) return -48'sh800000000000;
    else return v[CovW-1:0];
  endfunction

endpackage

>>> design/kab_mul.sv
// Shared 25 by 32 bit multiplier that forms round(a * k / 2^24) in two passes.
// Depends on kab_pkg.
module kab_mul (
  input  logic                            clk_i,
  input  kab_pkg::mul_ctl_t               ctl_i,
  input  logic signed [kab_pkg::CovW-1:0] a_i,
  input  logic signed [31:0]              k_i,
  output logic signed [kab_pkg::ProdW-1:0] res_o
);
  import kab_pkg::*;

  logic signed [24:0]      op_a;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] lo_sum;
  logic signed [32:0]      lo_q;
  logic signed [ProdW-1:0] res_q;

  assign op_a   = ctl_i.hi_en ? {a_i[47], a_i[47:24]} : {1'b0, a_i[23:0]};
  assign prod   = ProdW'(op_a * k_i);
  assign lo_sum = prod + 57'sd8388608;

  always_ff @(posedge clk_i) begin
    if (ctl_i.lo_en) begin
      lo_q <= lo_sum[56:24];
    end
    if (ctl_i.hi_en) begin
      res_q <= prod + ProdW'(lo_q);
    end
  end

  assign res_o = res_q;

endmodule

>>> design/kab_div.sv
// Restoring divider, one quotient bit a cycle, for the signed Q7.24 gain.
// Depends on kab_pkg.
module kab_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [kab_pkg::CovW-1:0] num_i,
  input  logic [kab_pkg::DenW-1:0]        den_i,
  output kab_pkg::div_stat_t              stat_o,
  output logic signed [31:0]              quot_o
);
  import kab_pkg::*;

  logic              busy_q, done_q, neg_q;
  logic [4:0]        cnt_q;
  logic [DenW-1:0]   rem_q, den_q;
  logic [6:0]        sh_q;
  logic [QuotW-1:0]  q_q;
  logic [CovW-1:0]   mag;
  logic [DenW:0]     trial;
  logic              fits;

  assign mag   = num_i[47] ? CovW'(-num_i) : CovW'(num_i);
  assign trial = {rem_q, sh_q[6]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        if ({7'b0, mag} >= {den_i, 7'b0}) begin
          done_q <= 1'b1;
        end else begin
          done_q <= 1'b0;
          busy_q <= 1'b1;
          cnt_q  <= 5'd31;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          done_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[47];
      den_q <= den_i;
      rem_q <= DenW'(mag[47:7]);
      sh_q  <= mag[6:0];
      q_q   <= '1;
    end else if (busy_q) begin
      rem_q <= fits ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      sh_q  <= {sh_q[5:0], 1'b0};
      q_q   <= {q_q[QuotW-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

endmodule

>>> design/kalman_angle_bias_filter.sv
// Two-state Kalman filter for angle and gyro bias, Q16.16 angles and Q8.40
// covariance. Each item runs ten rounded products, each through the states MUL_LO,
// MUL_HI and MUL_WB on the shared 25 by 32 bit multiplier, and two gain divisions
// on the one-bit-a-cycle divider (cut short when the gain saturates, skipped when
// the innovation variance is not positive), then hands the result over in FINISH
// and returns to IDLE, where the next beat is accepted. Input is stalled meanwhile,
// and for longer while a finished result waits behind a stalled output. Depends on
// kab_pkg, kab_mul and kab_div.
module kalman_angle_bias_filter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [31:0]  measured_angle_i,
  input  logic [31:0]  measured_rate_i,
  input  logic [23:0]  time_step_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [31:0]  filtered_angle_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [23:0]  cfg_data_i
);
  import kab_pkg::*;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   div_sel_q, div_sel_d;

  logic [NoiseW-1:0] angle_noise_q, bias_noise_q, measure_noise_q;
  logic signed [AngW-1:0] ang_q, bias_q, meas_q, rate_q, y_q;
  logic signed [CovW-1:0] aa_q, ab_q, ba_q, bb_q, inner_q;
  logic [NoiseW-1:0]      dt_q;
  logic signed [31:0]     k0_q, k1_q;
  logic [DenW-1:0]        s_q;
  logic                   out_valid_q;
  logic [31:0]            out_q;

  mul_ctl_t                mul_ctl;
  logic signed [CovW-1:0]  mul_a;
  logic signed [31:0]      mul_k;
  logic signed [ProdW-1:0] mul_res;
  logic signed [WideW-1:0] r;
  logic signed [WideW-1:0] s_wide;
  logic                    s_pos;
  div_stat_t               div_stat;
  logic signed [31:0]      div_quot;
  logic                    div_start;
  logic                    accept;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != ST_IDLE;
  assign r          = WideW'(mul_res);
  assign s_wide     = WideW'(aa_q) + WideW'({measure_noise_q, 16'b0});
  assign s_pos      = !s_wide[WideW-1] && (s_wide != '0);
  assign mul_ctl.lo_en = state_q == ST_MUL_LO;
  assign mul_ctl.hi_en = state_q == ST_MUL_HI;
  assign div_start  = state_q == ST_DIV_GO;

  always_comb begin
    mul_a = aa_q;
    mul_k = k0_q;
    case (op_q)
      OP_ANG_PRED: begin mul_a = CovW'(rate_q); mul_k = 32'(dt_q); end
      OP_BB_DT:    begin mul_a = bb_q; mul_k = 32'(dt_q); end
      OP_INNER_DT: begin mul_a = inner_q; mul_k = 32'(dt_q); end
      OP_QB_DT:    begin mul_a = CovW'({bias_noise_q, 16'b0}); mul_k = 32'(dt_q); end
      OP_Y_K0:     begin mul_a = CovW'(y_q); mul_k = k0_q; end
      OP_Y_K1:     begin mul_a = CovW'(y_q); mul_k = k1_q; end
      OP_BA:       begin mul_a = aa_q; mul_k = k1_q; end
      OP_BB:       begin mul_a = ab_q; mul_k = k1_q; end
      OP_AA:       begin mul_a = aa_q; mul_k = k0_q; end
      OP_AB:       begin mul_a = ab_q; mul_k = k0_q; end
      default:     begin mul_a = aa_q; mul_k = k0_q; end
    endcase
  end

  kab_mul u_mul (
    .clk_i (clk_i),
    .ctl_i (mul_ctl),
    .a_i   (mul_a),
    .k_i   (mul_k),
    .res_o (mul_res)
  );

  kab_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_sel_q ? ba_q : aa_q),
    .den_i   (s_q),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    div_sel_d = div_sel_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_MUL_LO;
          op_d    = OP_ANG_PRED;
        end
      end
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_MUL_WB;
      ST_MUL_WB: begin
        if (op_q == OP_AB) begin
          state_d = ST_FINISH;
        end else if (op_q == OP_QB_DT && s_pos) begin
          state_d   = ST_DIV_GO;
          div_sel_d = 1'b0;
        end else begin
          state_d = ST_MUL_LO;
          op_d    = op_e'(op_q + 4'd1);
        end
      end
      ST_DIV_GO: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          if (!div_sel_q) begin
            state_d   = ST_DIV_GO;
            div_sel_d = 1'b1;
          end else begin
            state_d = ST_MUL_LO;
            op_d    = OP_Y_K0;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      op_q            <= OP_ANG_PRED;
      div_sel_q       <= 1'b0;
      out_valid_q     <= 1'b0;
      angle_noise_q   <= AngleNoiseRst;
      bias_noise_q    <= BiasNoiseRst;
      measure_noise_q <= MeasureNoiseRst;
      ang_q           <= '0;
      bias_q          <= '0;
      aa_q            <= '0;
      ab_q            <= '0;
      ba_q            <= '0;
      bb_q            <= '0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      div_sel_q <= div_sel_d;
      if (state_q == ST_FINISH && state_d == ST_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegAngleNoise:   angle_noise_q   <= cfg_data_i;
          RegBiasNoise:    bias_noise_q    <= cfg_data_i;
          RegMeasureNoise: measure_noise_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_MUL_WB) begin
        case (op_q)
          OP_ANG_PRED: ang_q <= sat32(WideW'(ang_q) + r);
          OP_BB_DT: begin
            ab_q <= sat48(WideW'(ab_q) - r);
            ba_q <= sat48(WideW'(ba_q) - r);
          end
          OP_INNER_DT: aa_q <= sat48(WideW'(aa_q) + r);
          OP_QB_DT:    bb_q <= sat48(WideW'(bb_q) + r);
          OP_Y_K0:     ang_q <= sat32(WideW'(ang_q) + r);
          OP_Y_K1:     bias_q <= sat32(WideW'(bias_q) + r);
          OP_BA:       ba_q <= sat48(WideW'(ba_q) - r);
          OP_BB:       bb_q <= sat48(WideW'(bb_q) - r);
          OP_AA:       aa_q <= sat48(WideW'(aa_q) - r);
          OP_AB:       ab_q <= sat48(WideW'(ab_q) - r);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      meas_q <= measured_angle_i;
      dt_q   <= time_step_i;
      rate_q <= sat32(WideW'($signed(measured_rate_i)) - WideW'(bias_q));
    end
    if (state_q == ST_MUL_WB && op_q == OP_BB_DT) begin
      inner_q <= sat48(r - WideW'(ab_q) - WideW'(ba_q) + WideW'({angle_noise_q, 16'b0}));
    end
    if (state_q == ST_MUL_WB && op_q == OP_QB_DT) begin
      s_q  <= s_wide[DenW-1:0];
      y_q  <= sat32(WideW'(meas_q) - WideW'(ang_q));
      k0_q <= '0;
      k1_q <= '0;
    end
    if (state_q == ST_DIV_WAIT && div_stat.done) begin
      if (div_sel_q) begin
        k1_q <= div_quot;
      end else begin
        k0_q <= div_quot;
      end
    end
    if (state_q == ST_FINISH && state_d == ST_IDLE) begin
      out_q <= ang_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_angle_o = out_q;

endmodule

>>> design/kab_checker.sv
// Port-level checker of the angle and bias filter, bound to the top level.
// Depends on kalman_angle_bias_filter_macros.svh.
`include "kalman_angle_bias_filter_macros.svh"

module kab_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] filtered_angle_o
);

  `KAB_ASSERT_NEXT(busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `KAB_ASSERT_NEXT(out_held, out_valid_o && out_stall_i, out_valid_o)
  `KAB_ASSERT(out_rise_after_work, $rose(out_valid_o) |-> $past(in_stall_o))
  `KAB_ASSERT_NEXT(out_stable, out_valid_o && out_stall_i, $stable(filtered_angle_o))

endmodule

bind kalman_angle_bias_filter kab_checker u_kab_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .filtered_angle_o (filtered_angle_o)
);

>>> verif/tb_kalman_angle_bias_filter.sv
// Testbench of kalman_angle_bias_filter: drives angle, rate and time step beats
// through the valid/stall channels and checks each fused angle against its own
// fixed-point predictor. Depends on kab_pkg and the filter RTL only.
`timescale 1ns / 100ps

module tb_kalman_angle_bias_filter;
  import kab_pkg::*;

  localparam logic [1:0] RegUnused = 2'd3;
  localparam longint Max48 = 64'sh7FFF_FFFF_FFFF;
  localparam longint Min48 = -Max48 - 1;
  localparam longint Max32 = 64'sh7FFF_FFFF;
  localparam longint Min32 = -Max32 - 1;
  localparam longint CycleLimit = 2000000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] measured_angle_i;
  logic [31:0] measured_rate_i;
  logic [23:0] time_step_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] filtered_angle_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [23:0] cfg_data_i;

  kalman_angle_bias_filter dut (.*);

  logic [NoiseW-1:0] angle_noise_r, bias_noise_r, measure_noise_r;
  longint est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;
  logic [31:0] fused_angle_q[$];
  int errors, beats_sent, beats_checked, zero_gain_hits;
  bit tx_idle_on, rx_idle_on, rx_hold;
  longint cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Rounded product back to the format of a, ties going up.
  function automatic longint mul_round(longint a, longint k);
    longint hi, lo;
    hi = a >>> 24;
    lo = a - (hi <<< 24);
    return hi * k + ((lo * k + (64'sd1 <<< 23)) >>> 24);
  endfunction

  // Q7.24 gain, truncated toward zero, magnitude saturated.
  function automatic longint gain_div(longint p, longint s);
    longint unsigned mag, q, r, den;
    longint res;
    mag = p < 0 ? longint'(-p) : longint'(p);
    den = s;
    q = mag / den;
    r = mag % den;
    if (q >= 128) begin
      res = Max32;
    end else begin
      for (int i = 0; i < 24; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 1;
        end
      end
      res = longint'(q);
    end
    return p < 0 ? -res : res;
  endfunction

  function automatic logic [31:0] fuse_angle(logic signed [31:0] meas,
                                             logic signed [31:0] rate_in,
                                             logic [23:0] dt_in);
    longint dt, qa, qb, rm, rate, inner, s, k0, k1, y, p00, p01, bbdt;
    dt = longint'(dt_in);
    qa = longint'(angle_noise_r) <<< 16;
    qb = longint'(bias_noise_r) <<< 16;
    rm = longint'(measure_noise_r) <<< 16;
    k0 = 0;
    k1 = 0;
    rate = clamp(longint'(rate_in) - est_bias, Min32, Max32);
    est_angle = clamp(est_angle + mul_round(rate, dt), Min32, Max32);
    bbdt = mul_round(p_bb, dt);
    inner = clamp(bbdt - p_ab - p_ba + qa, Min48, Max48);
    p_aa = clamp(p_aa + mul_round(inner, dt), Min48, Max48);
    p_ab = clamp(p_ab - bbdt, Min48, Max48);
    p_ba = clamp(p_ba - bbdt, Min48, Max48);
    p_bb = clamp(p_bb + mul_round(qb, dt), Min48, Max48);
    s = p_aa + rm;
    if (s > 0) begin
      k0 = gain_div(p_aa, s);
      k1 = gain_div(p_ba, s);
    end else begin
      zero_gain_hits++;
    end
    y = clamp(longint'(meas) - est_angle, Min32, Max32);
    est_angle = clamp(est_angle + mul_round(y, k0), Min32, Max32);
    est_bias = clamp(est_bias + mul_round(y, k1), Min32, Max32);
    p00 = p_aa;
    p01 = p_ab;
    p_aa = clamp(p_aa - mul_round(p00, k0), Min48, Max48);
    p_ab = clamp(p_ab - mul_round(p01, k0), Min48, Max48);
    p_ba = clamp(p_ba - mul_round(p00, k1), Min48, Max48);
    p_bb = clamp(p_bb - mul_round(p01, k1), Min48, Max48);
    return est_angle[31:0];
  endfunction

  task automatic send_beat(logic [31:0] meas, logic [31:0] rate, logic [23:0] dt);
    bit taken;
    in_valid_i       <= 1'b1;
    measured_angle_i <= meas;
    measured_rate_i  <= rate;
    time_step_i      <= dt;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    fused_angle_q.push_back(fuse_angle(meas, rate, dt));
    beats_sent++;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (fused_angle_q.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegAngleNoise:   angle_noise_r   = value;
      RegBiasNoise:    bias_noise_r    = value;
      RegMeasureNoise: measure_noise_r = value;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return $urandom();
      default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    endcase
  endfunction

  function automatic logic [23:0] rand_step();
    case ($urandom_range(0, 3))
      0: return 24'($urandom());
      default: return 24'($urandom_range(8000, 40000));
    endcase
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_beat(rand_angle(), rand_angle(), rand_step());
  endtask

  task automatic test_field_extremes();
    send_beat(32'h0, 32'h0, 24'h0);
    send_beat(32'h7FFF_FFFF, 32'h0, 24'd16777);
    send_beat(32'h8000_0000, 32'h0, 24'd16777);
    send_beat(32'h0, 32'h7FFF_FFFF, 24'hFF_FFFF);
    send_beat(32'h0, 32'h8000_0000, 24'hFF_FFFF);
    send_beat(32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF);
    send_beat(32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF);
    send_beat(32'hFFFF_FFFF, 32'h0000_0001, 24'h00_0001);
    send_beat(32'h0001_0000, 32'hFFFF_0000, 24'h80_0000);
    send_beat(32'h5555_5555, 32'hAAAA_AAAA, 24'h55_5555);
    send_beat(32'hAAAA_AAAA, 32'h5555_5555, 24'hAA_AAAA);
  endtask

  // All noise settings zero: the first zero-step beat collapses the angle variance
  // to zero, so the other zero-step ones see a nonpositive innovation variance.
  task automatic test_zero_variance();
    write_reg(RegAngleNoise, 24'h0);
    write_reg(RegBiasNoise, 24'h0);
    write_reg(RegMeasureNoise, 24'h0);
    send_beat(32'h0002_0000, 32'h0, 24'h0);
    send_beat(32'hFFFE_0000, 32'h0001_0000, 24'h0);
    send_beat(32'h0003_0000, 32'h0, 24'h0);
    send_beat(32'h0001_0000, 32'h0001_0000, 24'd16777);
  endtask

  task automatic test_register_sweep();
    write_reg(RegUnused, 24'hFF_FFFF);
    send_random(10);
    write_reg(RegAngleNoise, 24'hFF_FFFF);
    write_reg(RegBiasNoise, 24'hFF_FFFF);
    write_reg(RegMeasureNoise, 24'h00_0001);
    send_random(30);
    write_reg(RegMeasureNoise, 24'hFF_FFFF);
    write_reg(RegAngleNoise, 24'h00_0001);
    write_reg(RegBiasNoise, 24'h0);
    send_random(30);
    write_reg(RegAngleNoise, AngleNoiseRst);
    write_reg(RegBiasNoise, BiasNoiseRst);
    write_reg(RegMeasureNoise, MeasureNoiseRst);
    send_random(30);
  endtask

  task automatic test_backpressure();
    fork
      begin
        rx_hold = 1'b1;
        repeat (600) @(posedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    send_random(8);
    drain();
  endtask

  task automatic test_random_traffic();
    send_random(300);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_random(80);
  endtask

  // Receiver: random stall bursts, plus the long hold.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold) begin
        out_stall_i <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18) - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result check; a beat seen valid and unstalled at the falling edge is taken
  // at the next rising edge.
  initial begin
    logic [31:0] want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (fused_angle_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time,
                   filtered_angle_o);
          errors++;
        end else begin
          want = fused_angle_q.pop_front();
          beats_checked++;
          if (filtered_angle_o !== want) begin
            $display("%0t: filtered_angle mismatch, expected %h, actual %h", $time,
                     want, filtered_angle_o);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("kalman_angle_bias_filter verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    measured_angle_i = '0;
    measured_rate_i = '0;
    time_step_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    angle_noise_r = AngleNoiseRst;
    bias_noise_r = BiasNoiseRst;
    measure_noise_r = MeasureNoiseRst;
    {est_angle, est_bias, p_aa, p_ab, p_ba, p_bb} = '0;
    errors = 0;
    beats_sent = 0;
    beats_checked = 0;
    zero_gain_hits = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    rx_hold = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_zero_variance();
    test_register_sweep();
    test_backpressure();
    test_random_traffic();
    drain();
    $display("Sent %0d beats and checked %0d fused angles, %0d with zero gain,",
             beats_sent, beats_checked, zero_gain_hits);
    $display("over extreme fields, all noise settings, long stalls and random idling.");
    if (errors == 0 && fused_angle_q.size() == 0) begin
      $display("kalman_angle_bias_filter verification clean");
    end else begin
      $display("kalman_angle_bias_filter verification failed");
    end
    $finish;
  end

endmodule
